[hw/rtl/rgbcv_pkg.sv]
// Shared types and constants for the RGB color vote classifier.
package rgbcv_pkg;

  localparam int WINDOW_BITS    = 16;
  localparam int ROUND_BITS     = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [WINDOW_BITS-1:0] WINDOW_TICKS_RESET = 16'd40000;
  localparam logic [ROUND_BITS-1:0]  VOTE_ROUNDS_RESET  = 4'd10;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_TICKS = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOTE_ROUNDS  = 1'd1;

  // Input action codes.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_GREEN = 2'd1,
    PH_BLUE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    COLOR_RED   = 2'd0,
    COLOR_GREEN = 2'd1,
    COLOR_BLUE  = 2'd2
  } color_t;

  // Control from the window sequencer to the vote tally.
  typedef struct packed {
    logic clear;
    logic finish;
  } tally_ctl_t;

  // Status from the vote tally back to the sequencer.
  typedef struct packed {
    logic   done;
    color_t color;
  } tally_res_t;

endpackage

[hw/rtl/rgbcv_if.sv]
// Valid/ready channel interfaces for the classifier's tick and result streams.
interface rgbcv_in_if;
  logic valid;
  logic ready;
  logic action;
  logic pulse_edge;

  modport source (output valid, action, pulse_edge, input ready);
  modport sink   (input valid, action, pulse_edge, output ready);
endinterface

interface rgbcv_out_if;
  logic       valid;
  logic       ready;
  logic       filter_s2;
  logic       filter_s3;
  logic       busy_res;
  logic       done_res;
  logic [1:0] color;

  modport source (output valid, filter_s2, filter_s3, busy_res, done_res, color,
                  input ready);
  modport sink   (input valid, filter_s2, filter_s3, busy_res, done_res, color,
                  output ready);
endinterface

[hw/rtl/rgbcv_tally.sv]
// Per-round vote counting and final majority decision.
module rgbcv_tally #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rgbcv_pkg::tally_ctl_t             ctl,
  input  logic [rgbcv_pkg::ROUND_BITS-1:0]  vote_rounds,
  input  logic [SAMPLE_BITS-1:0]            red_sample,
  input  logic [SAMPLE_BITS-1:0]            green_sample,
  input  logic [SAMPLE_BITS-1:0]            blue_sample,
  output rgbcv_pkg::tally_res_t             res
);

  logic [rgbcv_pkg::ROUND_BITS-1:0] red_votes;
  logic [rgbcv_pkg::ROUND_BITS-1:0] green_votes;
  logic [rgbcv_pkg::ROUND_BITS-1:0] blue_votes;
  logic [rgbcv_pkg::ROUND_BITS-1:0] round_count;
  logic [rgbcv_pkg::ROUND_BITS-1:0] red_votes_next;
  logic [rgbcv_pkg::ROUND_BITS-1:0] green_votes_next;
  logic [rgbcv_pkg::ROUND_BITS-1:0] blue_votes_next;
  logic [rgbcv_pkg::ROUND_BITS-1:0] round_count_next;
  logic red_wins;
  logic green_wins;
  logic blue_wins;

  // A vote goes only to a strictly greatest count.
  assign red_wins   = (red_sample > green_sample) && (red_sample > blue_sample);
  assign green_wins = (green_sample > red_sample) && (green_sample > blue_sample);
  assign blue_wins  = (blue_sample > green_sample) && (blue_sample > red_sample);

  always_comb begin
    red_votes_next   = red_votes;
    green_votes_next = green_votes;
    blue_votes_next  = blue_votes;
    if (red_wins) begin
      red_votes_next = red_votes + 1'b1;
    end else if (green_wins) begin
      green_votes_next = green_votes + 1'b1;
    end else if (blue_wins) begin
      blue_votes_next = blue_votes + 1'b1;
    end
    round_count_next = round_count + 1'b1;
  end

  always_comb begin
    res.done = ctl.finish && (round_count_next >= vote_rounds);
    if ((red_votes_next >= green_votes_next) && (red_votes_next >= blue_votes_next)) begin
      res.color = rgbcv_pkg::COLOR_RED;
    end else if (green_votes_next >= blue_votes_next) begin
      res.color = rgbcv_pkg::COLOR_GREEN;
    end else begin
      res.color = rgbcv_pkg::COLOR_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      red_votes   <= '0;
      green_votes <= '0;
      blue_votes  <= '0;
      round_count <= '0;
    end else if (ctl.finish) begin
      red_votes   <= red_votes_next;
      green_votes <= green_votes_next;
      blue_votes  <= blue_votes_next;
      round_count <= round_count_next;
    end
  end

  // Each finished round adds at most one vote.
  assert property (@(posedge clk) disable iff (rst)
    (ctl.finish && !ctl.clear) |=>
      ($countones({red_votes != $past(red_votes), green_votes != $past(green_votes),
                   blue_votes != $past(blue_votes)}) <= 1))
    else $error("more than one vote added in a round");

  // Done is only reported at the end of a round.
  assert property (@(posedge clk) disable iff (rst) res.done |-> ctl.finish)
    else $error("done without a finished round");

  // Blue is only reported when it has strictly more votes than red and green.
  assert property (@(posedge clk) disable iff (rst)
    (res.color == rgbcv_pkg::COLOR_BLUE) |->
      (blue_votes_next > red_votes_next && blue_votes_next > green_votes_next))
    else $error("blue chosen without a strict majority");

endmodule

[hw/rtl/rgb_color_vote_classifier.sv]
// Top level of the RGB color vote classifier for a frequency-output color sensor.
//
// Usage: the items channel carries one transaction per time tick (action = 0)
// with pulse_edge set when the sensor output had a falling edge in that tick,
// or a start request (action = 1). A start while a classification runs is
// ignored. Once started, the block steps the filter selects red, green, blue;
// each filter window lasts window_ticks ticks and its pulse count saturates.
// After each blue window one vote goes to the strictly greatest color, and
// after vote_rounds rounds the color with the most votes is reported with
// done_res (ties resolve to red, then green).
// Every accepted transaction produces exactly one result transaction showing
// the filter selects, busy flag, done flag and color after that step.
// The result is valid in the cycle after input acceptance; throughput is one
// transaction per cycle while the receiver takes each result, set by the single
// registered update of the sequencer state and the result register.
// When the result receiver stalls, the held result stays in the output
// register and items.ready drops until it is taken.
// Synchronous reset returns the block to idle, selects red, clears the last color
// and loads the register defaults (40000 ticks, 10 rounds). Configuration is
// to be written through cfg_we/cfg_index/cfg_data only while idle (unchecked).
module rgb_color_vote_classifier #(
  parameter int PULSE_COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rgbcv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rgbcv_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  rgbcv_in_if.sink                             items,
  rgbcv_out_if.source                          results
);

  // Configuration registers.
  logic [rgbcv_pkg::WINDOW_BITS-1:0] window_ticks;
  logic [rgbcv_pkg::ROUND_BITS-1:0]  vote_rounds;

  // Sequencer state.
  logic                              running;
  rgbcv_pkg::phase_t                 phase;
  logic [rgbcv_pkg::WINDOW_BITS-1:0] tick_count;
  logic [PULSE_COUNT_BITS-1:0]       pulse_count;
  logic [PULSE_COUNT_BITS-1:0]       red_sample;
  logic [PULSE_COUNT_BITS-1:0]       green_sample;
  rgbcv_pkg::color_t                 last_color;

  logic                              running_next;
  rgbcv_pkg::phase_t                 phase_next;
  logic [rgbcv_pkg::WINDOW_BITS-1:0] tick_count_next;
  logic [PULSE_COUNT_BITS-1:0]       pulse_count_next;
  rgbcv_pkg::color_t                 last_color_next;

  logic accept;
  logic start;
  logic tick;
  logic window_end;
  logic [rgbcv_pkg::WINDOW_BITS-1:0] tick_inc;
  logic [PULSE_COUNT_BITS-1:0]       pulse_inc;
  logic filter_s2_next;
  logic filter_s3_next;

  rgbcv_pkg::tally_ctl_t tally_ctl;
  rgbcv_pkg::tally_res_t tally_res;

  // The result register frees up whenever the receiver takes its content, so
  // a new tick can enter in the same cycle the previous result leaves.
  assign items.ready = !results.valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign start       = accept && (items.action == rgbcv_pkg::ACT_START) && !running;
  assign tick        = accept && (items.action == rgbcv_pkg::ACT_TICK) && running;

  // Tick counter wraps at 16 bits; a wrapped count also closes the window, and
  // a zero window behaves as one tick, since the first tick already reaches it.
  assign tick_inc   = tick_count + 1'b1;
  assign window_end = tick && ((tick_inc == '0) || (tick_inc >= window_ticks));
  assign pulse_inc  = (items.pulse_edge && !(&pulse_count)) ? pulse_count + 1'b1
                                                            : pulse_count;

  assign tally_ctl.clear  = start;
  assign tally_ctl.finish = window_end && (phase == rgbcv_pkg::PH_BLUE);

  rgbcv_tally #(
    .SAMPLE_BITS (PULSE_COUNT_BITS)
  ) u_tally (
    .clk          (clk),
    .rst          (rst),
    .ctl          (tally_ctl),
    .vote_rounds  (vote_rounds),
    .red_sample   (red_sample),
    .green_sample (green_sample),
    .blue_sample  (pulse_inc),
    .res          (tally_res)
  );

  // Filter phase: next state.
  always_comb begin
    phase_next = phase;
    if (start) begin
      phase_next = rgbcv_pkg::PH_RED;
    end else if (window_end) begin
      case (phase)
        rgbcv_pkg::PH_RED:   phase_next = rgbcv_pkg::PH_GREEN;
        rgbcv_pkg::PH_GREEN: phase_next = rgbcv_pkg::PH_BLUE;
        rgbcv_pkg::PH_BLUE:  phase_next = rgbcv_pkg::PH_RED;
        default:             phase_next = rgbcv_pkg::PH_RED;
      endcase
    end
  end

  // Filter phase: select outputs for the state after this step.
  always_comb begin
    case (phase_next)
      rgbcv_pkg::PH_RED: begin
        filter_s2_next = 1'b0;
        filter_s3_next = 1'b0;
      end
      rgbcv_pkg::PH_GREEN: begin
        filter_s2_next = 1'b1;
        filter_s3_next = 1'b1;
      end
      default: begin
        filter_s2_next = 1'b0;
        filter_s3_next = 1'b1;
      end
    endcase
  end

  // Counters, run flag and reported color.
  always_comb begin
    running_next     = running;
    tick_count_next  = tick_count;
    pulse_count_next = pulse_count;
    last_color_next  = last_color;
    if (start) begin
      running_next     = 1'b1;
      tick_count_next  = '0;
      pulse_count_next = '0;
    end else if (tick) begin
      if (window_end) begin
        tick_count_next  = '0;
        pulse_count_next = '0;
      end else begin
        tick_count_next  = tick_inc;
        pulse_count_next = pulse_inc;
      end
      if (tally_res.done) begin
        running_next    = 1'b0;
        last_color_next = tally_res.color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= rgbcv_pkg::WINDOW_TICKS_RESET;
      vote_rounds  <= rgbcv_pkg::VOTE_ROUNDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rgbcv_pkg::CFG_WINDOW_TICKS: window_ticks <= cfg_data[rgbcv_pkg::WINDOW_BITS-1:0];
        rgbcv_pkg::CFG_VOTE_ROUNDS:  vote_rounds  <= cfg_data[rgbcv_pkg::ROUND_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      phase        <= rgbcv_pkg::PH_RED;
      tick_count   <= '0;
      pulse_count  <= '0;
      red_sample   <= '0;
      green_sample <= '0;
      last_color   <= rgbcv_pkg::COLOR_RED;
    end else begin
      running     <= running_next;
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      pulse_count <= pulse_count_next;
      last_color  <= last_color_next;
      if (window_end && (phase == rgbcv_pkg::PH_RED)) begin
        red_sample <= pulse_inc;
      end
      if (window_end && (phase == rgbcv_pkg::PH_GREEN)) begin
        green_sample <= pulse_inc;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.filter_s2 <= filter_s2_next;
      results.filter_s3 <= filter_s3_next;
      results.busy_res  <= running_next;
      results.done_res  <= tally_res.done && tick;
      results.color     <= last_color_next;
    end
  end

  // A finished classification is never reported as still busy.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.done_res) |-> !results.busy_res)
    else $error("done reported while busy");

  // The filter selects rest on red whenever no classification runs.
  assert property (@(posedge clk) disable iff (rst)
    !running |-> (phase == rgbcv_pkg::PH_RED))
    else $error("phase not red while idle");

  // An accepted start while idle always begins a classification.
  assert property (@(posedge clk) disable iff (rst) start |=> running)
    else $error("start did not begin a classification");

  // A stalled result blocks further input.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |-> !items.ready)
    else $error("input accepted while result stalled");

endmodule
